FILE: hw/rtl/lwch_pkg.sv
// shared types and constants for the windowed loss count histogram
package lwch_pkg;

    localparam int SEQ_W       = 32;
    localparam int CNT_W       = 32;
    localparam int WS_W        = 6;
    localparam int BIN_W       = 6;
    localparam int CMD_W       = 2;
    localparam int DIV_W       = SEQ_W + 1;
    localparam int CFG_ADDR_W  = 1;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_PAD_W   = 2;
    localparam int OUT_TDATA_W = BIN_W + CNT_W + OUT_PAD_W;

    localparam logic [WS_W-1:0] WS_RESET = 6'd10;

    localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW_SIZE = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SEQ_LIMIT   = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_DROP  = 2'd0,
        CMD_END   = 2'd1,
        CMD_READ  = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV1,
        ST_DIV2,
        ST_RD_A,
        ST_WR_A,
        ST_RD_B,
        ST_WR_B,
        ST_FIN,
        ST_RREAD,
        ST_RLOAD
    } t_state;

endpackage

FILE: hw/rtl/windowed_loss_count_histogram.sv
// top level: windowed loss count histogram with a shared iterative divider
// drop inside the open window, clear, and end with nothing to close: handled in idle
// drop or end that closes windows: a divider pass, then a bin update, and a second one
// for bin 0 when more than one window closes; a drop that hits the limit adds a divider pass
// read: bins 0 to the effective window size, stalled while m_axis_tready is low
// synchronous active-low reset: histogram empty, window state and registers to reset values
module windowed_loss_count_histogram import lwch_pkg::*; #(
    parameter int MAX_WINDOW = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [SEQ_W-1:0]       i_cfg_wdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // drop_seq
    input  logic [CMD_W-1:0]       s_axis_tuser,   // command
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // bin_index, bin_count, zero pad
    output logic                   m_axis_tlast    // last_bin
);

    localparam int DEPTH = MAX_WINDOW + 1;
    localparam int IDX_W = $clog2(DEPTH);
    localparam logic [WS_W-1:0] WS_MAX = WS_W'(MAX_WINDOW);

    t_state             r_state, n_state;
    logic [WS_W-1:0]    r_cfg_ws;
    logic [SEQ_W-1:0]   r_cfg_max;
    logic [SEQ_W-1:0]   r_start;
    logic [WS_W-1:0]    r_drops;
    logic [SEQ_W-1:0]   r_seq;
    logic [SEQ_W-1:0]   r_newstart;
    logic [DIV_W-1:0]   r_k;
    logic               r_is_end;
    logic [IDX_W-1:0]   r_idx;

    logic [CNT_W-1:0]   mem [DEPTH];
    logic [DEPTH-1:0]   r_vld;
    logic [CNT_W-1:0]   r_rd_data;
    logic               r_rd_vld;

    logic               r_ovalid;
    logic [BIN_W-1:0]   r_o_index;
    logic [CNT_W-1:0]   r_o_count;
    logic               r_o_last;

    logic [WS_W-1:0]    ws_eff;
    t_cmd               in_cmd;
    logic [SEQ_W-1:0]   in_seq;
    logic               in_acc;
    logic               start_lt_max;
    logic               drop_live;
    logic               seq_ge_end;
    logic               close_req;
    logic [DIV_W-1:0]   avail_dividend;
    logic [SEQ_W-1:0]   seq_at;
    logic               seq_at_ge_max;
    logic               reopen;
    logic [IDX_W-1:0]   last_idx;
    logic [CNT_W-1:0]   rd_val;
    logic [CNT_W+1:0]   sum;
    logic [CNT_W-1:0]   sat_sum;

    logic               div_start;
    logic [DIV_W-1:0]   div_dividend;
    logic               div_done;
    logic [DIV_W-1:0]   div_quot;
    logic [WS_W-1:0]    div_rem;

    logic               mem_rd;
    logic               mem_wr;
    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   wr_addr;
    logic [DIV_W-1:0]   wr_amt;
    logic               out_load;

    always_comb begin
        if (r_cfg_ws == '0) begin
            ws_eff = WS_W'(1);
        end else if (r_cfg_ws > WS_MAX) begin
            ws_eff = WS_MAX;
        end else begin
            ws_eff = r_cfg_ws;
        end
    end

    assign in_cmd       = t_cmd'(s_axis_tuser);
    assign in_seq       = s_axis_tdata[SEQ_W-1:0];
    assign in_acc       = s_axis_tvalid && s_axis_tready;
    assign start_lt_max = r_start < r_cfg_max;
    assign drop_live    = start_lt_max && (in_seq >= r_start);
    assign seq_ge_end   = {1'b0, in_seq} >= ({1'b0, r_start} + DIV_W'(ws_eff));
    assign close_req    = (in_cmd == CMD_DROP && drop_live && seq_ge_end) ||
                          (in_cmd == CMD_END && start_lt_max);
    assign avail_dividend = {1'b0, r_cfg_max} - {1'b0, r_start} + DIV_W'(ws_eff)
                          - DIV_W'(1);
    assign seq_at        = r_seq - SEQ_W'(div_rem);
    assign seq_at_ge_max = seq_at >= r_cfg_max;
    assign reopen        = (r_newstart < r_cfg_max) && (r_seq >= r_newstart) &&
                           ({1'b0, r_seq} < ({1'b0, r_newstart} + DIV_W'(ws_eff)));
    assign last_idx      = IDX_W'(ws_eff);
    assign rd_val        = r_rd_vld ? r_rd_data : '0;
    assign sum           = {2'b00, rd_val} + {1'b0, wr_amt};
    assign sat_sum       = (sum[CNT_W+1:CNT_W] != 2'b00) ? '1 : sum[CNT_W-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (in_cmd)
                        CMD_DROP:  if (drop_live && seq_ge_end) n_state = ST_DIV1;
                        CMD_END:   if (start_lt_max) n_state = ST_DIV2;
                        CMD_READ:  n_state = ST_RREAD;
                        CMD_CLEAR: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_DIV1: if (div_done) n_state = seq_at_ge_max ? ST_DIV2 : ST_RD_A;
            ST_DIV2: if (div_done) n_state = ST_RD_A;
            ST_RD_A: n_state = ST_WR_A;
            ST_WR_A: n_state = (r_k > DIV_W'(1)) ? ST_RD_B : ST_FIN;
            ST_RD_B: n_state = ST_WR_B;
            ST_WR_B: n_state = ST_FIN;
            ST_FIN:  n_state = ST_IDLE;
            ST_RREAD: n_state = ST_RLOAD;
            ST_RLOAD: if (out_load) n_state = (r_idx == last_idx) ? ST_IDLE : ST_RREAD;
            default: n_state = ST_IDLE;
        endcase
    end

    // control decode
    always_comb begin
        div_start    = 1'b0;
        div_dividend = avail_dividend;
        mem_rd       = 1'b0;
        mem_wr       = 1'b0;
        rd_addr      = r_idx;
        wr_addr      = IDX_W'(r_drops);
        wr_amt       = DIV_W'(1);
        out_load     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                div_start = in_acc && close_req;
                if (in_cmd == CMD_DROP) begin
                    div_dividend = {1'b0, in_seq - r_start};
                end
            end
            ST_DIV1: div_start = div_done && seq_at_ge_max;
            ST_RD_A: begin
                mem_rd  = 1'b1;
                rd_addr = IDX_W'(r_drops);
            end
            ST_WR_A: mem_wr = 1'b1;
            ST_RD_B: begin
                mem_rd  = 1'b1;
                rd_addr = '0;
            end
            ST_WR_B: begin
                mem_wr  = 1'b1;
                wr_addr = '0;
                wr_amt  = r_k - DIV_W'(1);
            end
            ST_RREAD: mem_rd = 1'b1;
            ST_RLOAD: out_load = !r_ovalid || m_axis_tready;
            default: ;
        endcase
    end

    lwch_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (ws_eff),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cfg_ws  <= WS_RESET;
            r_cfg_max <= '0;
            r_start   <= SEQ_W'(1);
            r_drops   <= '0;
            r_vld     <= '0;
            r_ovalid  <= 1'b0;
            r_idx     <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_WINDOW_SIZE: r_cfg_ws  <= i_cfg_wdata[WS_W-1:0];
                    CFG_SEQ_LIMIT:   r_cfg_max <= i_cfg_wdata;
                endcase
            end
            if (in_acc) begin
                unique case (in_cmd)
                    CMD_DROP: begin
                        if (drop_live && !seq_ge_end && r_drops < ws_eff) begin
                            r_drops <= r_drops + 1'b1;
                        end
                    end
                    CMD_END: begin
                        if (!start_lt_max) begin
                            r_start <= SEQ_W'(1);
                            r_drops <= '0;
                        end
                    end
                    CMD_READ:  r_idx <= '0;
                    CMD_CLEAR: r_vld <= '0;
                endcase
            end
            if (mem_wr) begin
                r_vld[wr_addr] <= 1'b1;
            end
            if (r_state == ST_FIN) begin
                r_start <= r_is_end ? SEQ_W'(1) : r_newstart;
                r_drops <= (!r_is_end && reopen) ? WS_W'(1) : '0;
            end
            if (out_load) begin
                r_idx    <= r_idx + 1'b1;
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_seq    <= in_seq;
            r_is_end <= in_cmd == CMD_END;
        end
        if (r_state == ST_DIV1 && div_done) begin
            r_k        <= div_quot;
            r_newstart <= seq_at_ge_max ? r_cfg_max : seq_at;
        end
        if (r_state == ST_DIV2 && div_done) begin
            r_k <= div_quot;
        end
        if (out_load) begin
            r_o_index <= BIN_W'(r_idx);
            r_o_count <= rd_val;
            r_o_last  <= r_idx == last_idx;
        end
    end

    // histogram storage
    always_ff @(posedge i_clk) begin
        if (mem_wr) begin
            mem[wr_addr] <= sat_sum;
        end
        if (mem_rd) begin
            r_rd_data <= mem[rd_addr];
            r_rd_vld  <= r_vld[rd_addr];
        end
    end

    assign s_axis_tready = r_state == ST_IDLE;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_o_count, r_o_index};
    assign m_axis_tlast  = r_o_last;

endmodule

FILE: hw/rtl/lwch_div.sv
// radix-2 restoring divider, one quotient bit per cycle
module lwch_div import lwch_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_dividend,
    input  logic [WS_W-1:0]  i_divisor,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quot,
    output logic [WS_W-1:0]  o_rem
);

    localparam int STEP_W = $clog2(DIV_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [DIV_W-1:0]  r_q;
    logic [WS_W-1:0]   r_rem;

    logic [WS_W:0]     trial;
    logic              ge;
    logic [WS_W-1:0]   n_rem;

    always_comb begin
        trial = {r_rem, r_q[DIV_W-1]};
        ge    = trial >= {1'b0, i_divisor};
        n_rem = ge ? WS_W'(trial - {1'b0, i_divisor}) : WS_W'(trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == STEP_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_q   <= {r_q[DIV_W-2:0], ge};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;

endmodule

FILE: hw/rtl/lwch_chk.sv
// port-level checker for the windowed loss count histogram and its bind
module lwch_chk import lwch_pkg::*; #(
    parameter int MAX_WINDOW = 32
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic [CMD_W-1:0]       s_axis_tuser,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                   m_axis_tlast
);

    logic [BIN_W-1:0] r_exp_idx;
    logic             out_acc;

    assign out_acc = m_axis_tvalid && m_axis_tready;

    // expected bin index of the next readout request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_idx <= '0;
        end else if (out_acc) begin
            r_exp_idx <= m_axis_tlast ? '0 : m_axis_tdata[BIN_W-1:0] + 1'b1;
        end
    end

    a_bin_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> m_axis_tdata[BIN_W-1:0] == r_exp_idx)
        else $error("readout bins out of order");

    a_bin_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[BIN_W-1:0] <= BIN_W'(MAX_WINDOW))
        else $error("bin index beyond histogram");

    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_READ) |=> !s_axis_tready)
        else $error("input taken during readout");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("stalled output request changed");

endmodule

bind windowed_loss_count_histogram lwch_chk #(.MAX_WINDOW(MAX_WINDOW)) u_lwch_chk (.*);

FILE: sim/testbench.sv
// self-checking testbench for the windowed loss count histogram
module testbench import lwch_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_WIN       = 32;
    localparam int SETTLE_CYCLES = 100;
    localparam int TAIL_CYCLES   = 150;
    localparam int RANDOM_REQS   = 145;

    typedef struct packed {
        logic [BIN_W-1:0] idx;
        logic [CNT_W-1:0] count;
        logic             last;
    } t_bin_result;

    typedef struct {
        logic                  is_cfg;
        logic [CFG_ADDR_W-1:0] addr;
        logic [SEQ_W-1:0]      wdata;
        t_cmd                  cmd;
        logic [SEQ_W-1:0]      seq;
    } t_stim_op;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]  i_cfg_addr = '0;
    logic [SEQ_W-1:0]       i_cfg_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // drop_seq
    logic [CMD_W-1:0]       s_axis_tuser = '0;   // command
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // bin_index, bin_count, zero pad
    logic                   m_axis_tlast;        // last_bin

    windowed_loss_count_histogram #(
        .MAX_WINDOW(MAX_WIN)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    always #4 i_clk = ~i_clk;

    // histogram model state
    logic [CNT_W-1:0] hist_m [0:MAX_WIN];
    logic [WS_W-1:0]  ws_reg_m;
    logic [63:0]      max_seq_m;
    logic [63:0]      win_start_m;
    logic [63:0]      win_drops_m;

    t_stim_op    pending_ops [$];
    t_bin_result expected_bins [$];
    int          total_reqs = 0;
    int          accepted_cnt = 0;
    int          fail_cnt = 0;

    function automatic logic [63:0] eff_window();
        if (ws_reg_m == 0) return 64'd1;
        if (ws_reg_m > MAX_WIN) return 64'(MAX_WIN);
        return 64'(ws_reg_m);
    endfunction

    function automatic void bump_bin(input logic [63:0] idx, input logic [63:0] amount);
        logic [63:0] sum;
        int          b;
        b = (idx > MAX_WIN) ? MAX_WIN : int'(idx);
        sum = {32'b0, hist_m[b]} + amount;
        hist_m[b] = (sum > 64'hFFFF_FFFF) ? '1 : sum[CNT_W-1:0];
    endfunction

    function automatic void close_windows(input logic [63:0] k_in, input logic [63:0] ws);
        logic [63:0] k;
        logic [63:0] avail;
        k = k_in;
        if (k != 0 && win_start_m < max_seq_m) begin
            avail = (max_seq_m - win_start_m + ws - 1) / ws;
            if (k > avail) k = avail;
            bump_bin(win_drops_m, 64'd1);
            if (k > 1) bump_bin(64'd0, k - 1);
            win_drops_m = 0;
            win_start_m = win_start_m + k * ws;
            if (win_start_m > max_seq_m) win_start_m = max_seq_m;
        end
    endfunction

    function automatic void track_histogram(input t_cmd cmd, input logic [SEQ_W-1:0] seq);
        logic [63:0] ws;
        logic [63:0] s;
        t_bin_result r;
        ws = eff_window();
        s = {32'b0, seq};
        case (cmd)
            CMD_DROP: begin
                if (win_start_m < max_seq_m && s >= win_start_m) begin
                    if (s >= win_start_m + ws) close_windows((s - win_start_m) / ws, ws);
                    if (win_start_m < max_seq_m && s >= win_start_m &&
                        s < win_start_m + ws && win_drops_m < ws)
                        win_drops_m = win_drops_m + 1;
                end
            end
            CMD_END: begin
                if (win_start_m < max_seq_m)
                    close_windows((max_seq_m - win_start_m + ws - 1) / ws, ws);
                win_start_m = 1;
                win_drops_m = 0;
            end
            CMD_CLEAR: begin
                for (int i = 0; i <= MAX_WIN; i++) hist_m[i] = '0;
            end
            default: begin
                for (int i = 0; i <= int'(ws); i++) begin
                    r.idx = BIN_W'(i);
                    r.count = hist_m[i];
                    r.last = (i == int'(ws));
                    expected_bins.insert(expected_bins.size(), r);
                end
            end
        endcase
    endfunction

    function automatic void queue_req(input t_cmd cmd, input logic [SEQ_W-1:0] seq);
        t_stim_op op;
        op.is_cfg = 1'b0;
        op.addr = '0;
        op.wdata = '0;
        op.cmd = cmd;
        op.seq = seq;
        pending_ops.insert(pending_ops.size(), op);
        total_reqs++;
    endfunction

    function automatic void queue_cfg(input logic [CFG_ADDR_W-1:0] addr,
                                      input logic [SEQ_W-1:0] data);
        t_stim_op op;
        op.is_cfg = 1'b1;
        op.addr = addr;
        op.wdata = data;
        op.cmd = CMD_DROP;
        op.seq = '0;
        pending_ops.insert(pending_ops.size(), op);
    endfunction

    // ascending drops with random gaps, salted with out-of-order and repeated numbers
    function automatic void queue_drop_list(input int n, input int unsigned gap_hi);
        logic [63:0]      pos;
        logic [63:0]      gap;
        logic [SEQ_W-1:0] prev;
        pos = 0;
        prev = 1;
        repeat (n) begin
            case ($urandom_range(19))
                0: queue_req(CMD_DROP, $urandom);
                1: queue_req(CMD_DROP, '0);
                2: queue_req(CMD_DROP, prev);
                3: queue_req(CMD_DROP, prev >> 1);
                default: begin
                    gap = 64'($urandom_range(gap_hi, 1));
                    if ($urandom_range(7) == 0) gap = gap * $urandom_range(6, 2);
                    pos = pos + gap;
                    if (pos <= 64'hFFFF_FFFF) begin
                        prev = pos[SEQ_W-1:0];
                        queue_req(CMD_DROP, prev);
                    end
                end
            endcase
        end
    endfunction

    function automatic int idle_pct(input bit sink);
        if (accepted_cnt < total_reqs / 3) return sink ? 86 : 33;
        if (accepted_cnt < 2 * total_reqs / 3) return sink ? 33 : 86;
        return 0;
    endfunction

    // request driver
    t_stim_op         cur_op;
    logic             drv_hold;
    logic             nxt_valid;
    logic             nxt_we;
    int               settle_cnt;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            i_cfg_we <= 1'b0;
            settle_cnt = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                track_histogram(t_cmd'(s_axis_tuser), s_axis_tdata);
                accepted_cnt++;
            end
            if (s_axis_tvalid || expected_bins.size() != 0) settle_cnt = 0;
            else if (settle_cnt < SETTLE_CYCLES) settle_cnt++;
            drv_hold = s_axis_tvalid && !s_axis_tready;
            nxt_valid = drv_hold;
            nxt_we = 1'b0;
            if (!drv_hold && pending_ops.size() != 0) begin
                if (pending_ops[0].is_cfg) begin
                    if (settle_cnt >= SETTLE_CYCLES) begin
                        cur_op = pending_ops.pop_front();
                        nxt_we = 1'b1;
                        if (cur_op.addr == CFG_WINDOW_SIZE) ws_reg_m = cur_op.wdata[WS_W-1:0];
                        else max_seq_m = {32'b0, cur_op.wdata};
                        i_cfg_addr <= cur_op.addr;
                        i_cfg_wdata <= cur_op.wdata;
                    end
                end else if ($urandom_range(99) >= idle_pct(1'b0)) begin
                    cur_op = pending_ops.pop_front();
                    nxt_valid = 1'b1;
                    s_axis_tdata <= cur_op.seq;
                    s_axis_tuser <= cur_op.cmd;
                end
            end
            s_axis_tvalid <= nxt_valid;
            i_cfg_we <= nxt_we;
        end
    end

    // bin monitor
    t_bin_result      want;
    logic [BIN_W-1:0] got_idx;
    logic [CNT_W-1:0] got_cnt;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got_idx = m_axis_tdata[BIN_W-1:0];
                got_cnt = m_axis_tdata[BIN_W +: CNT_W];
                if (expected_bins.size() == 0) begin
                    $error("unexpected bin: bin_index %0d bin_count %0d", got_idx, got_cnt);
                    fail_cnt++;
                end else begin
                    want = expected_bins.pop_front();
                    if (got_idx !== want.idx) begin
                        $error("bin_index expected %0d got %0d", want.idx, got_idx);
                        fail_cnt++;
                    end
                    if (got_cnt !== want.count) begin
                        $error("bin_count expected %0d got %0d", want.count, got_cnt);
                        fail_cnt++;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $error("last_bin expected %0d got %0d", want.last, m_axis_tlast);
                        fail_cnt++;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= idle_pct(1'b1));
        end
    end

    // stimulus and end of run
    initial begin
        logic [WS_W-1:0]  ws_val;
        int unsigned      ws_eff;
        logic [SEQ_W-1:0] max_val;
        int unsigned      gap_hi;
        int               directed_reqs;

        ws_reg_m = WS_RESET;
        max_seq_m = 0;
        win_start_m = 1;
        win_drops_m = 0;
        for (int i = 0; i <= MAX_WIN; i++) hist_m[i] = '0;

        // short list: below window, repeat, out of order, gap, exhaustion
        queue_cfg(CFG_WINDOW_SIZE, 32'd10);
        queue_cfg(CFG_SEQ_LIMIT, 32'd100);
        queue_req(CMD_READ, '0);
        queue_req(CMD_DROP, 32'd0);
        queue_req(CMD_DROP, 32'd5);
        queue_req(CMD_DROP, 32'd5);
        queue_req(CMD_DROP, 32'd3);
        queue_req(CMD_DROP, 32'd37);
        queue_req(CMD_DROP, 32'd250);
        queue_req(CMD_DROP, 32'd260);
        queue_req(CMD_END, '1);
        queue_req(CMD_READ, '0);
        queue_req(CMD_CLEAR, '0);
        // whole sequence space with unit windows, twice, to saturate bin 0
        queue_cfg(CFG_WINDOW_SIZE, 32'd1);
        queue_cfg(CFG_SEQ_LIMIT, 32'hFFFF_FFFF);
        queue_req(CMD_DROP, 32'd1);
        queue_req(CMD_DROP, 32'd1);
        queue_req(CMD_DROP, 32'hFFFF_FFFF);
        queue_req(CMD_END, '0);
        queue_req(CMD_DROP, 32'd1);
        queue_req(CMD_DROP, 32'hFFFF_FFFF);
        queue_req(CMD_END, '0);
        queue_req(CMD_READ, '0);
        // window size changed in the middle of a list
        queue_cfg(CFG_WINDOW_SIZE, 32'd10);
        queue_cfg(CFG_SEQ_LIMIT, 32'd1000);
        queue_req(CMD_DROP, 32'd15);
        queue_cfg(CFG_WINDOW_SIZE, 32'd3);
        queue_req(CMD_DROP, 32'd40);
        queue_req(CMD_END, '0);
        queue_cfg(CFG_WINDOW_SIZE, 32'd63);
        queue_req(CMD_READ, '0);
        queue_cfg(CFG_WINDOW_SIZE, 32'd0);
        queue_cfg(CFG_SEQ_LIMIT, 32'd0);
        queue_req(CMD_DROP, 32'd7);
        queue_req(CMD_END, '0);
        queue_req(CMD_READ, '0);
        directed_reqs = total_reqs;

        while (total_reqs - directed_reqs < RANDOM_REQS) begin
            case ($urandom_range(7))
                0: ws_val = 6'd0;
                1: ws_val = 6'd1;
                2: ws_val = 6'd32;
                3: ws_val = 6'd63;
                default: ws_val = WS_W'($urandom_range(31, 2));
            endcase
            ws_eff = (ws_val == 0) ? 1 : (ws_val > MAX_WIN) ? MAX_WIN : ws_val;
            case ($urandom_range(9))
                0: begin
                    max_val = 32'hFFFF_FFFF;
                    gap_hi = 32'h2000_0000;
                end
                1: begin
                    max_val = $urandom;
                    gap_hi = $urandom_range(4000, 1);
                end
                default: begin
                    max_val = $urandom_range(ws_eff * 60, ws_eff * 4);
                    gap_hi = 2 * ws_eff;
                end
            endcase
            queue_cfg(CFG_WINDOW_SIZE, {26'b0, ws_val});
            queue_cfg(CFG_SEQ_LIMIT, max_val);
            repeat ($urandom_range(3, 1)) begin
                queue_drop_list($urandom_range(12, 4), gap_hi);
                queue_req(CMD_END, $urandom);
                if ($urandom_range(1) == 0) queue_req(CMD_READ, $urandom);
            end
            queue_req(CMD_READ, $urandom);
            if ($urandom_range(3) == 0) queue_req(CMD_CLEAR, $urandom);
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_ops.size() != 0 || s_axis_tvalid || expected_bins.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
